// ===== design/six_twelve_escape_to_ascii_decoder_core_macros.svh =====
// Assertion macros used by the checker file of the escape decoder.
`ifndef SIX_TWELVE_ESCAPE_TO_ASCII_DECODER_CORE_MACROS_SVH
`define SIX_TWELVE_ESCAPE_TO_ASCII_DECODER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define STE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define STE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ste_dec_pkg.sv =====
`timescale 1ns / 1ps

package ste_dec_pkg;

    // Pending prefix after the previous byte.
    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_AT    = 3'b010,
        ESC_CARET = 3'b100
    } t_esc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       reversible;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_code;

    // Zero, one or two results written to the result queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        t_res       first;
        t_res       second;
    } t_push;

    typedef struct packed {
        t_push push;
        t_esc  esc;
        logic  rev;
    } t_dec;

    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] BRACE_SHIFT = 8'h4B;
    localparam logic [7:0] DIGIT_BASE  = 8'h35;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    // Largest fill level at which the queue still has room for two results.
    localparam logic [OQ_AW:0] OQ_ROOM_MAX = (OQ_AW + 1)'(OQ_DEPTH - 2);

    function automatic t_code caret_code(input logic [7:0] c);
        t_code r;
        r.hit   = 1'b1;
        r.value = 8'h00;
        case (c) inside
            [8'h41:8'h5A]: r.value = c + CASE_OFFSET;
            [8'h61:8'h7A]: r.value = c;
            [8'h30:8'h33]: r.value = c + BRACE_SHIFT;
            [8'h35:8'h39]: r.value = c - DIGIT_BASE;
            8'h20: r.value = 8'd13;
            8'h21: r.value = 8'd22;
            8'h22: r.value = 8'd20;
            8'h23: r.value = 8'd16;
            8'h24: r.value = 8'd11;
            8'h25: r.value = 8'd19;
            8'h26: r.value = 8'd23;
            8'h27: r.value = 8'd24;
            8'h28: r.value = 8'd9;
            8'h29: r.value = 8'd10;
            8'h2A: r.value = 8'd7;
            8'h2B: r.value = 8'd5;
            8'h2C: r.value = 8'd14;
            8'h2D: r.value = 8'd6;
            8'h2E: r.value = 8'd15;
            8'h2F: r.value = 8'd8;
            8'h34: r.value = CH_DEL;
            8'h3B: r.value = 8'd31;
            8'h3C: r.value = 8'd26;
            8'h3D: r.value = 8'd12;
            8'h3E: r.value = 8'd27;
            8'h3F: r.value = 8'd25;
            8'h40: r.value = 8'd28;
            8'h5B: r.value = 8'd17;
            8'h5C: r.value = 8'd29;
            8'h5D: r.value = 8'd18;
            8'h5E: r.value = 8'd30;
            8'h5F: r.value = 8'd21;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_code at_code(input logic [7:0] c);
        t_code r;
        r.hit   = 1'b1;
        r.value = 8'h00;
        case (c)
            8'h41, 8'h61: r.value = CH_AT;
            8'h42, 8'h62: r.value = CH_CARET;
            8'h44, 8'h64: r.value = 8'h3A;
            8'h47, 8'h67: r.value = 8'h60;
            default:      r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ste_dec_in_if.sv =====
`timescale 1ns / 1ps

interface ste_dec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== design/ste_dec_out_if.sv =====
`timescale 1ns / 1ps

interface ste_dec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic       reversible;
    logic       last;

    modport source (
        output valid, output out_byte, output is_status, output reversible, output last,
        input ready
    );
    modport sink (
        input valid, input out_byte, input is_status, input reversible, input last,
        output ready
    );
endinterface

// ===== design/ste_dec_decode.sv =====
`timescale 1ns / 1ps

module ste_dec_decode (
    input  ste_dec_pkg::t_esc i_esc,
    input  logic              i_rev,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    output ste_dec_pkg::t_dec o_dec
);
    import ste_dec_pkg::*;

    logic       pending;
    logic [7:0] prefix;
    t_code      code;

    assign pending = (i_esc == ESC_AT) || (i_esc == ESC_CARET);
    assign prefix  = (i_esc == ESC_AT) ? CH_AT : CH_CARET;
    assign code    = (i_esc == ESC_AT) ? at_code(i_byte) : caret_code(i_byte);

    always_comb begin
        o_dec              = '0;
        o_dec.esc          = ESC_NONE;
        o_dec.rev          = i_rev;
        o_dec.push.count   = 2'd1;
        o_dec.push.first   = '{out_byte: i_byte, is_status: 1'b0, reversible: 1'b0,
                               last: 1'b1};
        o_dec.push.second  = '{out_byte: i_byte, is_status: 1'b0, reversible: 1'b0,
                               last: 1'b1};
        if (i_eoi) begin
            // A dangling prefix is flushed ahead of the status report.
            o_dec.rev = 1'b1;
            if (pending) begin
                o_dec.push.count  = 2'd2;
                o_dec.push.first  = '{out_byte: prefix, is_status: 1'b0, reversible: 1'b0,
                                      last: 1'b0};
                o_dec.push.second = '{out_byte: 8'h00, is_status: 1'b1, reversible: 1'b0,
                                      last: 1'b1};
            end else begin
                o_dec.push.first  = '{out_byte: 8'h00, is_status: 1'b1, reversible: i_rev,
                                      last: 1'b1};
            end
        end else if (pending) begin
            if (!code.hit) begin
                o_dec.rev         = 1'b0;
                o_dec.push.count  = 2'd2;
                o_dec.push.first  = '{out_byte: prefix, is_status: 1'b0, reversible: 1'b0,
                                      last: 1'b0};
            end else begin
                o_dec.push.first.out_byte = code.value;
                if (i_esc == ESC_CARET && i_byte == CH_RPAREN) begin
                    o_dec.rev = 1'b0;
                end
            end
        end else if (i_byte == CH_AT) begin
            o_dec.esc        = ESC_AT;
            o_dec.push.count = 2'd0;
        end else if (i_byte == CH_CARET) begin
            o_dec.esc        = ESC_CARET;
            o_dec.push.count = 2'd0;
        end
    end
endmodule

// ===== design/ste_dec_oq.sv =====
`timescale 1ns / 1ps

module ste_dec_oq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ste_dec_pkg::t_push i_push,
    input  logic               i_pop,
    output ste_dec_pkg::t_res  o_head,
    output logic               o_valid,
    output logic               o_room
);
    import ste_dec_pkg::*;

    t_res              r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wr_ptr;
    logic [OQ_AW-1:0]  r_rd_ptr;
    logic [OQ_AW:0]    r_count;
    logic [OQ_AW-1:0]  n_wr_ptr;
    logic [OQ_AW-1:0]  n_rd_ptr;
    logic [OQ_AW:0]    n_count;
    logic [OQ_AW-1:0]  wr_ptr_1;
    logic              do_pop;

    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= OQ_ROOM_MAX);
    assign o_head   = r_mem[r_rd_ptr];
    assign do_pop   = i_pop && o_valid;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + OQ_AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + OQ_AW'(do_pop);
        n_count  = r_count + (OQ_AW + 1)'(i_push.count) - (OQ_AW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end
endmodule

// ===== design/six_twelve_escape_to_ascii_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Payload                                  | Handshake
// i_in    | in  | in_byte[7:0], end_of_input               | valid/ready
// o_out   | out | out_byte[7:0], is_status, reversible, last | valid/ready
//
// One input request per cycle while the input is not stalled; a result passes the input register, then the queue.
// A request that yields two results writes both to the queue at once; the output presents them in turn.
// Input register feeds the decode, which writes a four-entry result queue.
// Input stalls only while the queue holds more than two results.
// Synchronous reset empties the pipeline and re-arms the reversible flag.
module six_twelve_escape_to_ascii_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ste_dec_in_if.sink    i_in,
    ste_dec_out_if.source o_out
);
    import ste_dec_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    t_esc       r_esc;
    logic       r_rev;
    logic       n_in_valid;

    logic       in_take;
    logic       stage_go;
    logic       oq_room;
    logic       oq_valid;
    t_dec       dec;
    t_push      push;
    t_res       head;

    assign in_take     = i_in.valid && i_in.ready;
    assign stage_go    = r_in_valid && oq_room;
    assign i_in.ready  = !r_in_valid || oq_room;
    assign n_in_valid  = in_take || (r_in_valid && !stage_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_esc      <= ESC_NONE;
            r_rev      <= 1'b1;
        end else begin
            r_in_valid <= n_in_valid;
            if (stage_go) begin
                r_esc <= dec.esc;
                r_rev <= dec.rev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.in_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    ste_dec_decode u_decode (
        .i_esc  (r_esc),
        .i_rev  (r_rev),
        .i_byte (r_in_byte),
        .i_eoi  (r_in_eoi),
        .o_dec  (dec)
    );

    always_comb begin
        push       = dec.push;
        push.count = stage_go ? dec.push.count : 2'd0;
    end

    ste_dec_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_head  (head),
        .o_valid (oq_valid),
        .o_room  (oq_room)
    );

    assign o_out.valid      = oq_valid;
    assign o_out.out_byte   = head.out_byte;
    assign o_out.is_status  = head.is_status;
    assign o_out.reversible = head.reversible;
    assign o_out.last       = head.last;
endmodule

// ===== design/ste_dec_chk.sv =====
`timescale 1ns / 1ps
`include "six_twelve_escape_to_ascii_decoder_core_macros.svh"

module ste_dec_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_is_status,
    input logic       i_out_reversible,
    input logic       i_out_last
);
    // A stalled result keeps its payload.
    `STE_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_is_status) && $stable(i_out_reversible) && $stable(i_out_last), "stalled result changed")

    `STE_ASSERT(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n) |-> !i_out_valid && i_in_ready, "pipeline not empty after reset")

    // When the output valid rises, its request was accepted and passed the input register and the result queue.
    `STE_ASSERT(a_out_latency, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "result without a request two cycles earlier")

    `STE_ASSERT(a_status_form, i_clk, i_rst_n, i_out_valid |-> (i_out_is_status ? (i_out_last && i_out_byte == 8'h00) : !i_out_reversible), "malformed result item")
endmodule

bind six_twelve_escape_to_ascii_decoder_core ste_dec_chk u_ste_dec_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_is_status  (o_out.is_status),
    .i_out_reversible (o_out.reversible),
    .i_out_last       (o_out.last)
);
